FILE: hdl/fbc_pkg.sv
// ============================================================================
// fbc_pkg: shared types, constants and functions for the Feistel cipher
// Payload structs, register indexes and the byte-wise round function.
// ============================================================================
package fbc_pkg;

    // Block geometry
    localparam int HALF_BYTES = 4;
    localparam int MAX_ROUNDS = 8;
    localparam int FIELD_W    = 32;
    // Bytes that can reach the 32-bit output fields
    localparam int LANES      = (HALF_BYTES < FIELD_W / 8) ? HALF_BYTES : FIELD_W / 8;
    localparam int DATA_W     = LANES * 8;

    // Key storage: eight key bytes, one per possible round
    localparam int KEY_SLOTS  = 8;
    localparam int KEY_IDX_W  = 3;
    localparam int ADD_W      = 5;   // k mod 17 fits in five bits
    localparam int CNT_W      = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_KEYS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 2'd1;
    localparam logic [CNT_W-1:0]     COUNT_RESET     = 4'd8;

    typedef enum logic
    {
        ACT_ENCRYPT = 1'b0,
        ACT_DECRYPT = 1'b1
    } action_t;

    typedef struct packed
    {
        logic              action;
        logic [FIELD_W-1:0] left_half;
        logic [FIELD_W-1:0] right_half;
    } blk_req_t;

    typedef struct packed
    {
        logic [FIELD_W-1:0] left_out;
        logic [FIELD_W-1:0] right_out;
    } blk_res_t;

    // Data held by one cell of the round chain
    typedef struct packed
    {
        logic              action;
        logic [DATA_W-1:0] l;
        logic [DATA_W-1:0] r;
    } fbc_stage_t;

    // Per-cell round control, derived from configuration
    typedef struct packed
    {
        logic             active;
        logic [ADD_W-1:0] enc_add;
        logic [ADD_W-1:0] dec_add;
    } fbc_ctl_t;

    // k mod 17 via reciprocal multiply (241/4096 ~ 1/17), exact for 8-bit k
    function automatic logic [ADD_W-1:0] key_mod17(input logic [7:0] k);
        logic [15:0] prod;
        logic [7:0]  quot;
        logic [7:0]  rem;
        prod = 16'(k) * 16'd241;
        quot = {4'b0, prod[15:12]};
        rem  = k - 8'(quot * 8'd17);
        return rem[ADD_W-1:0];
    endfunction

    // Add the same value to every byte, no carry between bytes
    function automatic logic [DATA_W-1:0] round_fn(input logic [DATA_W-1:0] h,
                                                   input logic [ADD_W-1:0]  add);
        logic [DATA_W-1:0] res;
        res = '0;
        for (int b = 0; b < LANES; b++)
        begin
            res[8*b +: 8] = h[8*b +: 8] + {3'b0, add};
        end
        return res;
    endfunction

endpackage

FILE: hdl/fbc_cell.sv
// ============================================================================
// fbc_cell: one round cell of the Feistel chain
// Holds one block, applies one encrypt or decrypt round (or passes it on
// when the round is beyond the configured count) and hands it downstream.
// ============================================================================
module fbc_cell
    import fbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  fbc_ctl_t   ctl,
    input  logic       up_valid,
    output logic       up_ready,
    input  fbc_stage_t up_data,
    output logic       dn_valid,
    input  logic       dn_ready,
    output fbc_stage_t dn_data
);

    logic       valid_reg;
    logic       valid_next;
    fbc_stage_t data_reg;
    fbc_stage_t data_next;
    logic       load;

    // Cell frees up when empty or when its block moves on
    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    // Round logic
    always_comb
    begin
        data_next = up_data;
        if (ctl.active)
        begin
            if (up_data.action == ACT_DECRYPT)
            begin
                data_next.l = up_data.r ^ round_fn(up_data.l, ctl.dec_add);
                data_next.r = up_data.l;
            end
            else
            begin
                data_next.l = up_data.r;
                data_next.r = up_data.l ^ round_fn(up_data.r, ctl.enc_add);
            end
        end
    end

    // Valid tracking
    always_comb
    begin
        valid_next = valid_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // A stalled block stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !dn_ready |=> valid_reg && $stable(data_reg))
        else $error("fbc_cell: stalled block lost or changed");

    // An empty cell always takes a request
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> up_ready)
        else $error("fbc_cell: empty cell refused a request");

    // A cell beyond the round count forwards the block unchanged
    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        load && !ctl.active |=> data_reg == $past(up_data))
        else $error("fbc_cell: inactive cell altered the block");

endmodule

FILE: hdl/feistel_block_cipher_unit.sv
// ============================================================================
// feistel_block_cipher_unit: pipelined Feistel cipher, one cell per round
// Chain of MAX_ROUNDS round cells; rounds beyond the count pass through.
// ============================================================================
// A request passes through the registers of all MAX_ROUNDS cells, in chain order, to the result.
// Throughput: one request per cycle while res_ready is high; each cell holds one block and forwards it.
// The last cell's register drives the result; bubbles let requests enter on stall.
// Reset: all cells empty, round_keys = 0, round_count = 8.
module feistel_block_cipher_unit
    import fbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  blk_valid,
    output logic                  blk_ready,
    input  blk_req_t              blk,
    output logic                  res_valid,
    input  logic                  res_ready,
    output blk_res_t              res,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [ADD_W-1:0] key_add_reg [KEY_SLOTS];
    logic [ADD_W-1:0] key_add_next [KEY_SLOTS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] n_rounds;

    fbc_ctl_t   ctl [MAX_ROUNDS];
    logic       chain_valid [MAX_ROUNDS+1];
    logic       chain_ready [MAX_ROUNDS+1];
    fbc_stage_t chain_data  [MAX_ROUNDS+1];

    assign cfg_ready = 1'b1;

    // Register writes; keys are stored already reduced mod 17
    always_comb
    begin
        key_add_next = key_add_reg;
        count_next   = count_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROUND_KEYS:
                begin
                    for (int i = 0; i < KEY_SLOTS; i++)
                    begin
                        key_add_next[i] = key_mod17(cfg_data[8*i +: 8]);
                    end
                end
                REG_ROUND_COUNT: count_next = cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                key_add_reg[i] <= '0;
            end
            count_reg <= COUNT_RESET;
        end
        else
        begin
            key_add_reg <= key_add_next;
            count_reg   <= count_next;
        end
    end

    // Saturate the round count
    assign n_rounds = (count_reg > CNT_W'(MAX_ROUNDS)) ? CNT_W'(MAX_ROUNDS) : count_reg;

    // Input stage: keep only the bytes of the half width
    assign chain_valid[0]       = blk_valid;
    assign blk_ready            = chain_ready[0];
    assign chain_data[0].action = blk.action;
    assign chain_data[0].l      = blk.left_half[DATA_W-1:0];
    assign chain_data[0].r      = blk.right_half[DATA_W-1:0];

    // Round cells
    for (genvar j = 0; j < MAX_ROUNDS; j++)
    begin : g_cell
        logic [CNT_W-1:0] dec_idx;

        assign dec_idx        = n_rounds - CNT_W'(j) - CNT_W'(1);
        assign ctl[j].active  = CNT_W'(j) < n_rounds;
        assign ctl[j].enc_add = key_add_reg[KEY_IDX_W'(j)];
        assign ctl[j].dec_add = key_add_reg[dec_idx[KEY_IDX_W-1:0]];

        fbc_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl[j]),
            .up_valid (chain_valid[j]),
            .up_ready (chain_ready[j]),
            .up_data  (chain_data[j]),
            .dn_valid (chain_valid[j+1]),
            .dn_ready (chain_ready[j+1]),
            .dn_data  (chain_data[j+1])
        );
    end

    // Result from the last cell
    assign chain_ready[MAX_ROUNDS] = res_ready;
    assign res_valid               = chain_valid[MAX_ROUNDS];
    assign res.left_out            = FIELD_W'(chain_data[MAX_ROUNDS].l);
    assign res.right_out           = FIELD_W'(chain_data[MAX_ROUNDS].r);

    // Configured count never exceeds the chain
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        n_rounds <= CNT_W'(MAX_ROUNDS))
        else $error("feistel_block_cipher_unit: round count not saturated");

    // A round-count write lands on the next cycle
    a_count_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == REG_ROUND_COUNT |=> count_reg == $past(cfg_data[CNT_W-1:0]))
        else $error("feistel_block_cipher_unit: round count write lost");

    // Active cells form a prefix of the chain
    a_active_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl[0].active |-> !ctl[MAX_ROUNDS-1].active)
        else $error("feistel_block_cipher_unit: round enables out of order");

endmodule

FILE: verif/feistel_block_cipher_unit_test.sv
// ============================================================================
// feistel_block_cipher_unit_test: self-checking bench for the Feistel cipher
// Drives blocks and register writes through valid/ready channels with random
// idle cycles on both sides, and predicts every result in a scoreboard.
// ============================================================================
module feistel_block_cipher_unit_test
    import fbc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Indexes past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int PHASES         = 10;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int IDLE_PCT       = 16;
    localparam int MAX_PRINTS     = 100;

    // Scoreboard: copy of the registers plus the queue of expected blocks
    class cipher_scoreboard;
        logic [63:0]      keys;
        logic [CNT_W-1:0] count;
        blk_res_t         expected_q[$];
        int               errors;

        function new();
            keys   = '0;
            count  = COUNT_RESET;
            errors = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0]  idx,
                                   input logic [CFG_DATA_W-1:0] data);
            if (idx == REG_ROUND_KEYS)
                keys = data;
            else if (idx == REG_ROUND_COUNT)
                count = data[CNT_W-1:0];
        endfunction

        // Same offset (key mod 17) added to each byte, no carry across bytes
        function logic [FIELD_W-1:0] add_key_bytes(input logic [FIELD_W-1:0] h,
                                                   input logic [7:0]         k);
            logic [FIELD_W-1:0] sum;
            logic [7:0]         offset;
            sum    = '0;
            offset = k % 8'd17;
            for (int i = 0; i < HALF_BYTES && i < FIELD_W / 8; i++)
            begin
                sum[8*i +: 8] = h[8*i +: 8] + offset;
            end
            return sum;
        endfunction

        function blk_res_t cipher_block(input blk_req_t b);
            logic [FIELD_W-1:0] mask;
            logic [FIELD_W-1:0] lh;
            logic [FIELD_W-1:0] rh;
            logic [FIELD_W-1:0] tmp;
            int                 rounds;
            blk_res_t           out;
            mask = '0;
            for (int i = 0; i < HALF_BYTES && i < FIELD_W / 8; i++)
            begin
                mask[8*i +: 8] = 8'hFF;
            end
            lh     = b.left_half & mask;
            rh     = b.right_half & mask;
            rounds = (count > MAX_ROUNDS) ? MAX_ROUNDS : int'(count);
            if (b.action == ACT_DECRYPT)
            begin
                for (int i = rounds - 1; i >= 0; i--)
                begin
                    tmp = rh ^ add_key_bytes(lh, keys[8*i +: 8]);
                    rh  = lh;
                    lh  = tmp;
                end
            end
            else
            begin
                for (int i = 0; i < rounds; i++)
                begin
                    tmp = lh ^ add_key_bytes(rh, keys[8*i +: 8]);
                    lh  = rh;
                    rh  = tmp;
                end
            end
            out.left_out  = lh;
            out.right_out = rh;
            return out;
        endfunction

        function void note_request(input blk_req_t b);
            expected_q.push_back(cipher_block(b));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(input string msg);
            if (errors < MAX_PRINTS)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(input blk_res_t got);
            blk_res_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h_%h",
                                          got.left_out, got.right_out));
                return;
            end
            want = expected_q.pop_front();
            if (got.left_out !== want.left_out)
                report_mismatch($sformatf("left_out %h, expected %h",
                                          got.left_out, want.left_out));
            if (got.right_out !== want.right_out)
                report_mismatch($sformatf("right_out %h, expected %h",
                                          got.right_out, want.right_out));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  blk_valid = 1'b0;
    logic                  blk_ready;
    blk_req_t              blk       = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    blk_res_t              res;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    bit                    idle_on   = 1'b1;
    cipher_scoreboard      sb;

    feistel_block_cipher_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk       (blk),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side back-pressure
    always @(posedge clk)
    begin
        res_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitors: note accepted requests and register writes, check results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
            if (blk_valid && blk_ready)
                sb.note_request(blk);
            if (res_valid && res_ready)
                sb.check_result(res);
        end
    end

    function automatic blk_req_t make_req(input action_t act,
                                          input logic [FIELD_W-1:0] l,
                                          input logic [FIELD_W-1:0] r);
        blk_req_t b;
        b.action     = act;
        b.left_half  = l;
        b.right_half = r;
        return b;
    endfunction

    // Mostly random words, with the extremes mixed in
    function automatic logic [FIELD_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Send one request; valid stays high afterwards unless the next call idles
    task automatic send_block(input blk_req_t b);
        int gap;
        gap = 0;
        if (idle_on)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        if (gap > 0)
        begin
            blk_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        blk_valid <= 1'b1;
        blk       <= b;
        @(posedge clk);
        while (!blk_ready)
            @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic pause_until_drained();
        blk_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Register write; valid is left high for back-to-back writes
    task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic apply_config(input logic [63:0] keys, input logic [CNT_W-1:0] count,
                                input bit spare_writes);
        pause_until_drained();
        write_register(REG_ROUND_KEYS, keys);
        write_register(REG_ROUND_COUNT, CFG_DATA_W'(count));
        if (spare_writes)
        begin
            write_register(REG_SPARE_LO, {$urandom, $urandom});
            write_register(REG_SPARE_HI, {$urandom, $urandom});
        end
        cfg_valid <= 1'b0;
    endtask

    // Main stimulus
    initial
    begin
        logic [63:0]      keys;
        logic [CNT_W-1:0] count;
        int               guard;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: zero keys, eight rounds
        send_block(make_req(ACT_ENCRYPT, '0, '0));
        send_block(make_req(ACT_ENCRYPT, '1, 32'h0123_4567));
        send_block(make_req(ACT_DECRYPT, 32'hA5A5_A5A5, '1));
        send_block(make_req(ACT_DECRYPT, 32'h5A5A_5A5A, 32'h8000_0001));

        // Key bytes at the modulus edges, single round
        apply_config(64'hAB0F_00EF_FF21_1110, 4'd1, 1'b0);
        send_block(make_req(ACT_ENCRYPT, 32'hFFFF_FFFF, 32'hFFF0_0F01));
        send_block(make_req(ACT_DECRYPT, 32'hF0F0_F0F0, 32'h0000_00FF));
        send_block(make_req(ACT_ENCRYPT, 32'h8000_0000, 32'h7FFF_FFFF));

        // Zero rounds: halves pass straight through
        apply_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0);
        send_block(make_req(ACT_ENCRYPT, 32'hDEAD_BEEF, 32'h1234_5678));
        send_block(make_req(ACT_DECRYPT, '1, '0));
        send_block(make_req(ACT_ENCRYPT, '0, '1));

        // Count above the maximum saturates; writes past the register list ignored
        apply_config(64'h1021_3243_5465_7687, 4'd15, 1'b1);
        send_block(make_req(ACT_ENCRYPT, 32'hFEDC_BA98, 32'h7654_3210));
        send_block(make_req(ACT_DECRYPT, 32'hFEDC_BA98, 32'h7654_3210));
        send_block(make_req(ACT_ENCRYPT, '1, '1));

        apply_config(64'hEFEF_1111_2222_FFFF, 4'd9, 1'b1);
        send_block(make_req(ACT_DECRYPT, 32'h0F0F_0F0F, 32'hF0F0_F0F0));
        send_block(make_req(ACT_ENCRYPT, 32'h0000_0001, 32'h8000_0000));

        apply_config(64'hFFEE_DDCC_BBAA_9988, 4'd8, 1'b0);
        send_block(make_req(ACT_ENCRYPT, 32'h0000_FFFF, 32'hFFFF_0000));
        send_block(make_req(ACT_DECRYPT, 32'h0000_FFFF, 32'hFFFF_0000));

        // Random phases, each under its own configuration
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       count = 4'd8;
                1:       count = 4'd1;
                2:       count = 4'd0;
                3:       count = 4'd15;
                default: count = 4'($urandom_range(15));
            endcase
            keys = (p == 0) ? '1 : {$urandom, $urandom};
            apply_config(keys, count, p == 7);
            idle_on = !(p == 5 || p == 6);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == 4 && i == ITEMS_PER_PHASE / 2)
                    pause_until_drained();
                send_block(make_req(action_t'($urandom_range(1)), pick_word(),
                                    pick_word()));
            end
        end
        idle_on = 1'b1;

        // Drain, then allow for any stray result
        blk_valid <= 1'b0;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (sb.pending() != 0 && guard < 5000);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        repeat (4 * MAX_ROUNDS) @(posedge clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("timeout waiting for the block");
        $display("CHECK FAILED");
        $finish;
    end

endmodule
